### rtl/acs_pkg.sv
// acs_pkg: shared types and constants of the affinity chunk scheduler.
// No dependencies; used by acs_table and affinity_chunk_scheduler_unit.
`default_nettype none

package acs_pkg;

    localparam int CHUNK_BITS = 10;
    localparam int TC_BITS    = 5;
    localparam int TID_BITS   = 4;

    typedef logic [CHUNK_BITS-1:0] t_chunks;
    typedef logic [TC_BITS-1:0]    t_thread_count;
    typedef logic [TID_BITS-1:0]   t_tid;
    typedef logic [0:0]            t_cfg_idx;
    typedef logic [0:0]            t_kind;

    localparam t_chunks       CHUNK_MAX          = '1;
    localparam int            TOTAL_ITERS_RESET  = 1024;
    localparam t_thread_count THREAD_COUNT_RESET = 5'd4;

    localparam t_cfg_idx CFG_TOTAL_ITERS  = 1'b0;
    localparam t_cfg_idx CFG_THREAD_COUNT = 1'b1;

    localparam t_kind KIND_START   = 1'b0;
    localparam t_kind KIND_REQUEST = 1'b1;

endpackage

`default_nettype wire

### rtl/acs_div.sv
// acs_div: restoring divider, one quotient bit per cycle.
// Stand-alone; shared by every ceiling division of the scheduler.
`default_nettype none

module acs_div #(
    parameter int DIV_BITS = 25,
    parameter int DEN_BITS = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DIV_BITS-1:0] i_dividend,
    input  wire logic [DEN_BITS-1:0] i_divisor,
    output logic                     o_done,
    output logic [DIV_BITS-1:0]      o_quotient
);

    localparam int CW = $clog2(DIV_BITS + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [DEN_BITS-1:0] r_rem, n_rem;
    logic [DIV_BITS-1:0] r_quo, n_quo;
    logic [DEN_BITS-1:0] r_den, n_den;

    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS:0]   w_diff;
    logic                w_ge;

    assign w_trial = {r_rem, r_quo[DIV_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DIV_BITS);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so DEN_BITS hold it
            n_rem = w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
            n_quo = {r_quo[DIV_BITS-2:0], w_ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### rtl/acs_table.sv
// acs_table: per-worker share state (next start, share end, chunks left).
// One write and one registered read port; depends on acs_pkg.
`default_nettype none

module acs_table #(
    parameter int MAX_WORKERS = 16,
    parameter int ITER_BITS   = 24,
    parameter int WIDX        = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_we,
    input  wire logic [WIDX-1:0]      i_waddr,
    input  wire logic [ITER_BITS-1:0] i_wnext,
    input  wire logic [ITER_BITS-1:0] i_wend,
    input  wire acs_pkg::t_chunks     i_wchunks,
    input  wire logic [WIDX-1:0]      i_raddr,
    output logic [ITER_BITS-1:0]      o_rnext,
    output logic [ITER_BITS-1:0]      o_rend,
    output acs_pkg::t_chunks          o_rchunks
);

    localparam int EW = 2 * ITER_BITS + acs_pkg::CHUNK_BITS;

    logic [EW-1:0] r_mem [MAX_WORKERS];
    logic [EW-1:0] r_rd;
    // a start sweep writes every entry; before the first one all read as zero
    logic          r_init, n_init;

    always_comb begin
        n_init = r_init;
        if (i_we && i_waddr == WIDX'(MAX_WORKERS - 1)) begin
            n_init = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
        end else begin
            r_init <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wnext, i_wend, i_wchunks};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rnext   = r_init ? r_rd[EW-1 -: ITER_BITS] : '0;
    assign o_rend    = r_init ? r_rd[acs_pkg::CHUNK_BITS +: ITER_BITS] : '0;
    assign o_rchunks = r_init ? r_rd[acs_pkg::CHUNK_BITS-1:0] : '0;

endmodule

`default_nettype wire

### rtl/affinity_chunk_scheduler_unit.sv
// Request: the own share is read from the table and the divider sets the grant size,
// with no division when the rest of the share is below P.
// Stealing scans the table entry of each active worker, then reads the donor.
// Start: a division gives the iterations per worker, then all MAX_WORKERS slots are
// swept, counting chunks by division and a tail below P as one chunk. One word at a time.
// Synchronous active-low reset; the worker table reads as empty until the first start.
`default_nettype none

module affinity_chunk_scheduler_unit #(
    parameter int MAX_WORKERS = 16,
    parameter int ITER_BITS   = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_kind,
    input  wire logic [acs_pkg::TID_BITS-1:0]   i_thread_id,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_has_work,
    output logic [ITER_BITS-1:0]                o_chunk_start,
    output logic [ITER_BITS-1:0]                o_chunk_end,
    output logic [acs_pkg::TID_BITS-1:0]        o_source_thread,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [ITER_BITS-1:0]           i_cfg_data
);

    localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int PW   = $clog2(MAX_WORKERS + 1);
    localparam int IB   = ITER_BITS;
    localparam int DVB  = ITER_BITS + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ST_IPT   = 4'd1;
    localparam logic [3:0] S_ST_IPT_W = 4'd2;
    localparam logic [3:0] S_ST_SHARE = 4'd3;
    localparam logic [3:0] S_ST_WALK  = 4'd4;
    localparam logic [3:0] S_ST_WDIV  = 4'd5;
    localparam logic [3:0] S_OWN_W    = 4'd6;
    localparam logic [3:0] S_SCAN_RD  = 4'd7;
    localparam logic [3:0] S_SCAN_CMP = 4'd8;
    localparam logic [3:0] S_SRC_RD   = 4'd9;
    localparam logic [3:0] S_SRC_W    = 4'd10;
    localparam logic [3:0] S_GRANT    = 4'd11;
    localparam logic [3:0] S_GRANT_DW = 4'd12;
    localparam logic [3:0] S_GRANT_WR = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    // control
    logic [3:0]                    r_state, n_state;
    logic                          r_out_valid, n_out_valid;
    logic [IB-1:0]                 r_total_iters, n_total_iters;
    acs_pkg::t_thread_count        r_thread_count, n_thread_count;

    // working registers
    logic [PW-1:0]                 r_p, n_p;
    logic [PW-1:0]                 r_t, n_t;
    acs_pkg::t_chunks              r_best, n_best;
    logic                          r_found, n_found;
    logic [WIDX-1:0]               r_src, n_src;
    logic [IB-1:0]                 r_s, n_s;
    logic [IB-1:0]                 r_e, n_e;
    acs_pkg::t_chunks              r_cl, n_cl;
    logic [IB-1:0]                 r_size, n_size;
    logic [IB-1:0]                 r_ipt, n_ipt;
    logic [DVB-1:0]                r_acc, n_acc;
    logic [IB-1:0]                 r_lo, n_lo;
    logic [IB-1:0]                 r_hi, n_hi;
    logic [IB-1:0]                 r_cur, n_cur;
    acs_pkg::t_chunks              r_cnt, n_cnt;
    logic                          r_res_has, n_res_has;
    logic [IB-1:0]                 r_res_start, n_res_start;
    logic [IB-1:0]                 r_res_end, n_res_end;
    logic [acs_pkg::TID_BITS-1:0]  r_res_src, n_res_src;
    logic                          r_out_has, n_out_has;
    logic [IB-1:0]                 r_out_start, n_out_start;
    logic [IB-1:0]                 r_out_end, n_out_end;
    logic [acs_pkg::TID_BITS-1:0]  r_out_src, n_out_src;

    logic [PW-1:0]                 w_p;
    logic                          w_in_acc;
    logic [IB-1:0]                 w_walk_rem;
    logic [IB-1:0]                 w_g_rem;
    logic [IB-1:0]                 w_rem_sel;
    logic [DVB-1:0]                w_acc_nx;
    logic [IB-1:0]                 w_lo;
    logic [IB-1:0]                 w_hi;
    logic [PW-1:0]                 w_t_inc;
    logic                          w_hit;
    acs_pkg::t_chunks              w_cnt_inc;

    logic                          w_div_start;
    logic [DVB-1:0]                w_div_dvd;
    logic                          w_div_done;
    logic [DVB-1:0]                w_div_quo;

    logic                          w_tbl_we;
    logic [WIDX-1:0]               w_tbl_waddr;
    logic [IB-1:0]                 w_tbl_wnext;
    logic [IB-1:0]                 w_tbl_wend;
    acs_pkg::t_chunks              w_tbl_wchunks;
    logic [WIDX-1:0]               w_tbl_raddr;
    logic [IB-1:0]                 w_tbl_rnext;
    logic [IB-1:0]                 w_tbl_rend;
    acs_pkg::t_chunks              w_tbl_rchunks;

    acs_div #(
        .DIV_BITS (DVB),
        .DEN_BITS (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (r_p),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    acs_table #(
        .MAX_WORKERS (MAX_WORKERS),
        .ITER_BITS   (ITER_BITS),
        .WIDX        (WIDX)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_tbl_we),
        .i_waddr   (w_tbl_waddr),
        .i_wnext   (w_tbl_wnext),
        .i_wend    (w_tbl_wend),
        .i_wchunks (w_tbl_wchunks),
        .i_raddr   (w_tbl_raddr),
        .o_rnext   (w_tbl_rnext),
        .o_rend    (w_tbl_rend),
        .o_rchunks (w_tbl_rchunks)
    );

    // worker count clamped to [1, MAX_WORKERS]
    always_comb begin
        if (r_thread_count == '0) begin
            w_p = PW'(1);
        end else if (int'(r_thread_count) > MAX_WORKERS) begin
            w_p = PW'(MAX_WORKERS);
        end else begin
            w_p = PW'(r_thread_count);
        end
    end

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_walk_rem = r_hi - r_cur;
    assign w_g_rem    = (r_e > r_s) ? (r_e - r_s) : '0;
    assign w_rem_sel  = (r_state == S_ST_WALK) ? w_walk_rem : w_g_rem;
    assign w_acc_nx   = r_acc + {1'b0, r_ipt};
    assign w_lo       = (r_acc > {1'b0, r_total_iters}) ? r_total_iters : r_acc[IB-1:0];
    assign w_hi       = (w_acc_nx > {1'b0, r_total_iters}) ? r_total_iters : w_acc_nx[IB-1:0];
    assign w_t_inc    = r_t + PW'(1);
    assign w_hit      = (w_tbl_rchunks > r_best);
    assign w_cnt_inc  = (r_cnt == acs_pkg::CHUNK_MAX) ? r_cnt : r_cnt + acs_pkg::t_chunks'(1);

    // ceil(x / p) as floor((x + p - 1) / p)
    always_comb begin
        if (r_state == S_ST_IPT) begin
            w_div_dvd = {1'b0, r_total_iters} + DVB'(r_p) - DVB'(1);
        end else begin
            w_div_dvd = {1'b0, w_rem_sel} + DVB'(r_p) - DVB'(1);
        end
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && i_out_stall;
        n_total_iters  = r_total_iters;
        n_thread_count = r_thread_count;
        n_p            = r_p;
        n_t            = r_t;
        n_best         = r_best;
        n_found        = r_found;
        n_src          = r_src;
        n_s            = r_s;
        n_e            = r_e;
        n_cl           = r_cl;
        n_size         = r_size;
        n_ipt          = r_ipt;
        n_acc          = r_acc;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_cur          = r_cur;
        n_cnt          = r_cnt;
        n_res_has      = r_res_has;
        n_res_start    = r_res_start;
        n_res_end      = r_res_end;
        n_res_src      = r_res_src;
        n_out_has      = r_out_has;
        n_out_start    = r_out_start;
        n_out_end      = r_out_end;
        n_out_src      = r_out_src;
        w_div_start    = 1'b0;
        w_tbl_we       = 1'b0;
        w_tbl_waddr    = r_src;
        w_tbl_wnext    = r_s + r_size;
        w_tbl_wend     = r_e;
        w_tbl_wchunks  = r_cl - acs_pkg::t_chunks'(1);
        w_tbl_raddr    = r_src;

        if (i_cfg_we) begin
            case (i_cfg_index)
                acs_pkg::CFG_TOTAL_ITERS:  n_total_iters  = i_cfg_data;
                acs_pkg::CFG_THREAD_COUNT: n_thread_count = i_cfg_data[acs_pkg::TC_BITS-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                w_tbl_raddr = WIDX'(i_thread_id);
                if (w_in_acc) begin
                    n_p         = w_p;
                    n_src       = WIDX'(i_thread_id);
                    n_res_has   = 1'b0;
                    n_res_start = '0;
                    n_res_end   = '0;
                    n_res_src   = '0;
                    if (i_kind == acs_pkg::KIND_START) begin
                        n_t     = '0;
                        n_acc   = '0;
                        n_state = S_ST_IPT;
                    end else if (i_thread_id >= w_p) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_OWN_W;
                    end
                end
            end
            S_ST_IPT: begin
                w_div_start = 1'b1;
                n_state     = S_ST_IPT_W;
            end
            S_ST_IPT_W: begin
                if (w_div_done) begin
                    n_ipt   = w_div_quo[IB-1:0];
                    n_state = S_ST_SHARE;
                end
            end
            S_ST_SHARE: begin
                if (r_t < r_p) begin
                    n_lo  = w_lo;
                    n_hi  = w_hi;
                    n_cur = w_lo;
                    n_acc = w_acc_nx;
                end else begin
                    n_lo  = '0;
                    n_hi  = '0;
                    n_cur = '0;
                end
                n_cnt   = '0;
                n_state = S_ST_WALK;
            end
            S_ST_WALK: begin
                if (r_cur >= r_hi) begin
                    w_tbl_we      = 1'b1;
                    w_tbl_waddr   = r_t[WIDX-1:0];
                    w_tbl_wnext   = r_lo;
                    w_tbl_wend    = r_hi;
                    w_tbl_wchunks = r_cnt;
                    if (r_t == PW'(MAX_WORKERS - 1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_t     = w_t_inc;
                        n_state = S_ST_SHARE;
                    end
                end else if (w_walk_rem < IB'(r_p)) begin
                    // tail smaller than P goes out as one chunk
                    n_cur = r_hi;
                    n_cnt = w_cnt_inc;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_ST_WDIV;
                end
            end
            S_ST_WDIV: begin
                if (w_div_done) begin
                    n_cur   = r_cur + w_div_quo[IB-1:0];
                    n_cnt   = w_cnt_inc;
                    n_state = S_ST_WALK;
                end
            end
            S_OWN_W: begin
                if (w_tbl_rchunks != '0) begin
                    n_s     = w_tbl_rnext;
                    n_e     = w_tbl_rend;
                    n_cl    = w_tbl_rchunks;
                    n_state = S_GRANT;
                end else begin
                    n_t     = '0;
                    n_best  = acs_pkg::t_chunks'(1);
                    n_found = 1'b0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                w_tbl_raddr = r_t[WIDX-1:0];
                n_state     = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // strict compare keeps the lowest-numbered worker on ties
                if (w_hit) begin
                    n_best  = w_tbl_rchunks;
                    n_src   = r_t[WIDX-1:0];
                    n_found = 1'b1;
                end
                if (w_t_inc == r_p) begin
                    n_state = (r_found || w_hit) ? S_SRC_RD : S_OUT;
                end else begin
                    n_t     = w_t_inc;
                    n_state = S_SCAN_RD;
                end
            end
            S_SRC_RD: begin
                n_state = S_SRC_W;
            end
            S_SRC_W: begin
                n_s     = w_tbl_rnext;
                n_e     = w_tbl_rend;
                n_cl    = w_tbl_rchunks;
                n_state = S_GRANT;
            end
            S_GRANT: begin
                if (w_g_rem < IB'(r_p)) begin
                    n_size  = w_g_rem;
                    n_state = S_GRANT_WR;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_GRANT_DW;
                end
            end
            S_GRANT_DW: begin
                if (w_div_done) begin
                    n_size  = w_div_quo[IB-1:0];
                    n_state = S_GRANT_WR;
                end
            end
            S_GRANT_WR: begin
                w_tbl_we    = 1'b1;
                n_res_has   = 1'b1;
                n_res_start = r_s;
                n_res_end   = r_s + r_size;
                n_res_src   = acs_pkg::TID_BITS'(r_src);
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_has   = r_res_has;
                    n_out_start = r_res_start;
                    n_out_end   = r_res_end;
                    n_out_src   = r_res_src;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_total_iters  <= IB'(acs_pkg::TOTAL_ITERS_RESET);
            r_thread_count <= acs_pkg::THREAD_COUNT_RESET;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_total_iters  <= n_total_iters;
            r_thread_count <= n_thread_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p         <= n_p;
        r_t         <= n_t;
        r_best      <= n_best;
        r_found     <= n_found;
        r_src       <= n_src;
        r_s         <= n_s;
        r_e         <= n_e;
        r_cl        <= n_cl;
        r_size      <= n_size;
        r_ipt       <= n_ipt;
        r_acc       <= n_acc;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_cur       <= n_cur;
        r_cnt       <= n_cnt;
        r_res_has   <= n_res_has;
        r_res_start <= n_res_start;
        r_res_end   <= n_res_end;
        r_res_src   <= n_res_src;
        r_out_has   <= n_out_has;
        r_out_start <= n_out_start;
        r_out_end   <= n_out_end;
        r_out_src   <= n_out_src;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_has_work      = r_out_has;
    assign o_chunk_start   = r_out_start;
    assign o_chunk_end     = r_out_end;
    assign o_source_thread = r_out_src;

`ifndef SYNTH
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_ST_IPT_W || r_state == S_ST_WDIV ||
                        r_state == S_GRANT_DW))
        else $error("divider finished with no state waiting on it");

    a_grant_has_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRANT_WR) |-> (r_cl != '0))
        else $error("grant from a worker with no chunks left");

    a_steal_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRC_RD) |-> (r_found && r_best > acs_pkg::t_chunks'(1)))
        else $error("steal from a worker holding fewer than two chunks");

    a_walk_in_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST_WALK) |-> (r_cur <= r_hi))
        else $error("chunk walk ran past the share end");
`endif

endmodule

`default_nettype wire
